// ===== rtl/sjp_pkg.sv =====
// Shared types and constants of the staged joint PD servo.
// Stage and register codes, fixed widths, the stage request bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sjp_pkg;

    localparam int ANGLE_W    = 32;
    localparam int GAIN_W     = 31;
    localparam int JOINT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int ERR_W      = 33;
    localparam int FRAC_W     = 16;
    localparam int DIGIT_W    = 4;
    localparam int MAC_STEPS  = 9;
    localparam int STEP_W     = 4;
    localparam int ACC_W      = 40;
    localparam int LO_W       = DIGIT_W * MAC_STEPS;
    localparam int KEEP_W     = ANGLE_W - (LO_W - FRAC_W);

    localparam logic [30:0] THRESHOLD_RESET = 31'd1966080;

    typedef logic [1:0] stage_t;
    localparam stage_t STAGE_TRAJ1 = 2'd0;
    localparam stage_t STAGE_TRAJ2 = 2'd1;
    localparam stage_t STAGE_HOLD  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_THRESHOLD  = 2'd0;
    localparam cfg_idx_t CFG_GAIN_INDEX = 2'd1;
    localparam cfg_idx_t CFG_P_GAIN     = 2'd2;
    localparam cfg_idx_t CFG_D_GAIN     = 2'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_PRIME  = 1'b1;

    typedef struct packed {
        logic update;
        logic stage1_ok;
        logic stage2_ok;
    } stage_req_t;

endpackage

`default_nettype wire

// ===== rtl/sjp_stage_ctl.sv =====
// Stage register of the servo: first trajectory, second trajectory, hold.
// Advances on the first joint of a tick; checks foot torques once.
// Depends on sjp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjp_stage_ctl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sjp_pkg::stage_req_t req,
    input  wire logic signed [31:0] torque_right,
    input  wire logic signed [31:0] torque_left,
    input  wire logic [30:0]        threshold,
    output sjp_pkg::stage_t         stage_now
);

    sjp_pkg::stage_t stage_reg;
    sjp_pkg::stage_t stage_next;
    logic            pending_reg;
    logic            pending_next;
    logic [31:0]     mag_right;
    logic [31:0]     mag_left;
    logic            foot_low;

    assign mag_right = torque_right[31] ? (~torque_right + 32'd1) : torque_right;
    assign mag_left  = torque_left[31]  ? (~torque_left + 32'd1)  : torque_left;
    assign foot_low  = (mag_right < {1'b0, threshold}) || (mag_left < {1'b0, threshold});

    always_comb
    begin
        stage_next   = stage_reg;
        pending_next = pending_reg;
        if (req.update)
        begin
            if ((stage_next == sjp_pkg::STAGE_TRAJ1) && !req.stage1_ok)
            begin
                stage_next = sjp_pkg::STAGE_TRAJ2;
            end
            if (stage_next == sjp_pkg::STAGE_TRAJ2)
            begin
                if (!req.stage2_ok || (pending_reg && foot_low))
                begin
                    stage_next = sjp_pkg::STAGE_HOLD;
                end
                pending_next = 1'b0;
            end
        end
    end

    assign stage_now = stage_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= sjp_pkg::STAGE_TRAJ1;
            pending_reg <= 1'b1;
        end
        else
        begin
            stage_reg   <= stage_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sjp_mac.sv =====
// Digit-serial multiply-accumulate: P*ep + D*ev, one radix-16 digit per cycle.
// Ends with floor division by 2^16 and 32-bit saturation.
// Depends on sjp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjp_mac (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [30:0]        p_gain,
    input  wire logic [30:0]        d_gain,
    input  wire logic signed [32:0] ep,
    input  wire logic signed [32:0] ev,
    output logic                    done,
    output logic [31:0]             torque,
    output logic                    saturated
);

    localparam int AW = sjp_pkg::ACC_W;
    localparam int LW = sjp_pkg::LO_W;
    localparam int KW = sjp_pkg::KEEP_W;
    localparam int DW = sjp_pkg::DIGIT_W;
    localparam int PPW = sjp_pkg::GAIN_W + DW + 2;

    logic                             run_reg;
    logic                             done_reg;
    logic [sjp_pkg::STEP_W-1:0]       cnt_reg;
    logic signed [sjp_pkg::ERR_W-1:0] ep_sh_reg;
    logic signed [sjp_pkg::ERR_W-1:0] ev_sh_reg;
    logic [sjp_pkg::GAIN_W-1:0]       p_reg;
    logic [sjp_pkg::GAIN_W-1:0]       d_reg;
    logic signed [AW-1:0]             acc_reg;
    logic [LW-1:0]                    lo_reg;

    logic                             last_step;
    logic signed [DW:0]               dig_p;
    logic signed [DW:0]               dig_d;
    logic signed [PPW-1:0]            pp_p;
    logic signed [PPW-1:0]            pp_d;
    logic signed [AW-1:0]             sum;
    logic [AW-KW:0]                   acc_hi;
    logic                             fits;

    assign last_step = (cnt_reg == sjp_pkg::STEP_W'(sjp_pkg::MAC_STEPS - 1));
    assign dig_p = last_step ? ep_sh_reg[DW:0] : $signed({1'b0, ep_sh_reg[DW-1:0]});
    assign dig_d = last_step ? ev_sh_reg[DW:0] : $signed({1'b0, ev_sh_reg[DW-1:0]});
    assign pp_p  = $signed({1'b0, p_reg}) * dig_p;
    assign pp_d  = $signed({1'b0, d_reg}) * dig_d;
    assign sum   = acc_reg + AW'(pp_p) + AW'(pp_d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + sjp_pkg::STEP_W'(1);
            if (last_step)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg     <= p_gain;
            d_reg     <= d_gain;
            ep_sh_reg <= ep;
            ev_sh_reg <= ev;
            acc_reg   <= '0;
            lo_reg    <= '0;
        end
        else if (run_reg)
        begin
            ep_sh_reg <= ep_sh_reg >>> DW;
            ev_sh_reg <= ev_sh_reg >>> DW;
            lo_reg    <= {sum[DW-1:0], lo_reg[LW-1:DW]};
            acc_reg   <= sum >>> DW;
        end
    end

    assign acc_hi    = acc_reg[AW-1:KW-1];
    assign fits      = (&acc_hi) | ~(|acc_hi);
    assign done      = done_reg;
    assign saturated = ~fits;
    assign torque    = fits ? {acc_reg[KW-1:0], lo_reg[LW-1:sjp_pkg::FRAC_W]}
                            : (acc_reg[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

endmodule

`default_nettype wire

// ===== rtl/staged_joint_pd_servo.sv =====
// Top level of the staged joint PD servo: channels, register port, joint memories.
// Sequences each sample through velocity, error and the digit-serial MAC.
// Depends on sjp_pkg, sjp_stage_ctl, sjp_mac.
//
//   port group   direction  handshake           payload
//   cfg          in         cfg_we              cfg_index, cfg_wdata
//   in           in         in_valid/in_stall   func .. torque_left_foot
//   out          out        out_valid/out_stall out_joint, torque_cmd, stage, saturated
//
// A control sample runs from its accepting edge to the next accept through the
// memory read, error, velocity product, nine radix-16 MAC steps and the output
// load, held by out_stall. Prime or out-of-range samples keep the sequencer idle.
// Reset sets the stage and the register file to reset values and clears the
// previous-angle and held-target valid bits; no clearing pass is needed.
// A result waits in the output register under out_stall while the next beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module staged_joint_pd_servo #(
    parameter int JOINTS         = 32,
    parameter int SAMPLE_RATE_HZ = 500
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_wdata,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic [4:0]         joint_index,
    input  wire logic signed [31:0] angle_measured,
    input  wire logic signed [31:0] angle_target,
    input  wire logic signed [31:0] vel_target,
    input  wire logic               stage1_line_ok,
    input  wire logic               stage2_line_ok,
    input  wire logic signed [31:0] torque_right_foot,
    input  wire logic signed [31:0] torque_left_foot,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [4:0]              out_joint,
    output logic signed [31:0]      torque_cmd,
    output sjp_pkg::stage_t         stage,
    output logic                    saturated
);

    localparam int ADDR_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int RATE_W = $clog2(SAMPLE_RATE_HZ + 1);
    localparam int PROD_W = sjp_pkg::ERR_W + RATE_W + 1;
    localparam int AW     = sjp_pkg::ANGLE_W;
    localparam int EW     = sjp_pkg::ERR_W;
    localparam int GW     = sjp_pkg::GAIN_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_VEL  = 5'b00100,
        S_ERR  = 5'b01000,
        S_MAC  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // register file
    logic [30:0] thr_reg;
    logic [4:0]  gain_idx_reg;
    logic [30:0] p_word_reg;
    logic        wr_thr;
    logic        wr_gidx;
    logic        wr_p;
    logic        wr_d;
    logic        gain_in_range;
    logic        gain_we;
    logic [ADDR_W-1:0] gain_addr;

    // memories
    logic signed [AW-1:0] prev_mem [JOINTS];
    logic signed [AW-1:0] held_mem [JOINTS];
    logic [2*GW-1:0]      gain_mem [JOINTS];
    logic signed [AW-1:0] prev_rd_reg;
    logic signed [AW-1:0] held_rd_reg;
    logic [2*GW-1:0]      gain_rd_reg;
    logic [JOINTS-1:0]    prev_vld_reg;
    logic [JOINTS-1:0]    held_vld_reg;

    // accept
    logic                in_accept;
    logic                in_range;
    logic                take_sample;
    logic [ADDR_W-1:0]   in_addr;
    sjp_pkg::stage_req_t stage_req;
    sjp_pkg::stage_t     stage_now;
    logic                hold_now;

    // item
    logic [4:0]           joint_reg;
    logic signed [AW-1:0] q_reg;
    logic signed [AW-1:0] target_reg;
    logic signed [AW-1:0] vref_reg;
    sjp_pkg::stage_t      stage_used_reg;
    logic                 prev_hit_reg;
    logic                 held_hit_reg;
    logic                 hold_item;

    // datapath
    logic signed [AW-1:0]     prev_eff;
    logic signed [AW-1:0]     ref_eff;
    logic signed [EW-1:0]     ep_reg;
    logic signed [EW-1:0]     diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-AW:0]       prod_hi;
    logic                     vel_fits;
    logic signed [AW-1:0]     vel;
    logic signed [AW-1:0]     vref_eff;
    logic signed [EW-1:0]     ev;

    logic        mac_start;
    logic        mac_done;
    logic [31:0] mac_torque;
    logic        mac_sat;

    // output
    logic                 out_free;
    logic                 out_load;
    logic                 out_valid_reg;
    logic [4:0]           out_joint_reg;
    logic signed [AW-1:0] torque_reg;
    sjp_pkg::stage_t      stage_out_reg;
    logic                 sat_reg;

    // ---------------- register port ----------------
    always_comb
    begin
        wr_thr  = 1'b0;
        wr_gidx = 1'b0;
        wr_p    = 1'b0;
        wr_d    = 1'b0;
        unique case (cfg_index)
            sjp_pkg::CFG_THRESHOLD:  wr_thr  = cfg_we;
            sjp_pkg::CFG_GAIN_INDEX: wr_gidx = cfg_we;
            sjp_pkg::CFG_P_GAIN:     wr_p    = cfg_we;
            sjp_pkg::CFG_D_GAIN:     wr_d    = cfg_we;
            default:                 wr_thr  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= sjp_pkg::THRESHOLD_RESET;
            gain_idx_reg <= '0;
            p_word_reg   <= '0;
        end
        else
        begin
            if (wr_thr)
            begin
                thr_reg <= cfg_wdata;
            end
            if (wr_gidx)
            begin
                gain_idx_reg <= cfg_wdata[4:0];
            end
            if (wr_p)
            begin
                p_word_reg <= cfg_wdata;
            end
        end
    end

    assign gain_in_range = ({27'd0, gain_idx_reg} < 32'(JOINTS));
    assign gain_we       = wr_d && gain_in_range;
    assign gain_addr     = ADDR_W'(gain_idx_reg);

    // ---------------- accept ----------------
    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign in_range    = ({27'd0, joint_index} < 32'(JOINTS));
    assign in_addr     = ADDR_W'(joint_index);
    assign take_sample = in_accept && in_range && (func == sjp_pkg::FUNC_SAMPLE);

    assign stage_req.update    = take_sample && (joint_index == 5'd0);
    assign stage_req.stage1_ok = stage1_line_ok;
    assign stage_req.stage2_ok = stage2_line_ok;

    sjp_stage_ctl u_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (stage_req),
        .torque_right (torque_right_foot),
        .torque_left  (torque_left_foot),
        .threshold    (thr_reg),
        .stage_now    (stage_now)
    );

    assign hold_now = (stage_now == sjp_pkg::STAGE_HOLD);

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept && in_range)
        begin
            prev_mem[in_addr] <= angle_measured;
        end
        if (take_sample)
        begin
            prev_rd_reg <= prev_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sample && !hold_now)
        begin
            held_mem[in_addr] <= angle_target;
        end
        if (take_sample)
        begin
            held_rd_reg <= held_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gain_we)
        begin
            gain_mem[gain_addr] <= {p_word_reg, cfg_wdata};
        end
        if (take_sample)
        begin
            gain_rd_reg <= gain_mem[in_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_vld_reg <= '0;
            held_vld_reg <= '0;
        end
        else
        begin
            if (in_accept && in_range)
            begin
                prev_vld_reg[in_addr] <= 1'b1;
            end
            if (take_sample && !hold_now)
            begin
                held_vld_reg[in_addr] <= 1'b1;
            end
        end
    end

    // ---------------- datapath ----------------
    assign hold_item = (stage_used_reg == sjp_pkg::STAGE_HOLD);
    assign prev_eff  = prev_hit_reg ? prev_rd_reg : '0;
    assign ref_eff   = hold_item ? (held_hit_reg ? held_rd_reg : '0) : target_reg;

    assign prod_hi  = prod_reg[PROD_W-1:AW-1];
    assign vel_fits = (&prod_hi) | ~(|prod_hi);
    assign vel      = vel_fits ? prod_reg[AW-1:0]
                               : (prod_reg[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    assign vref_eff = hold_item ? '0 : vref_reg;
    assign ev       = EW'(vref_eff) - EW'(vel);

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            joint_reg      <= joint_index;
            q_reg          <= angle_measured;
            target_reg     <= angle_target;
            vref_reg       <= vel_target;
            stage_used_reg <= stage_now;
            prev_hit_reg   <= prev_vld_reg[in_addr];
            held_hit_reg   <= held_vld_reg[in_addr];
        end
        if (state_reg == S_LOAD)
        begin
            ep_reg   <= EW'(ref_eff) - EW'(q_reg);
            diff_reg <= EW'(q_reg) - EW'(prev_eff);
        end
        if (state_reg == S_VEL)
        begin
            prod_reg <= diff_reg * $signed({1'b0, RATE_W'(SAMPLE_RATE_HZ)});
        end
    end

    assign mac_start = (state_reg == S_ERR);

    sjp_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mac_start),
        .p_gain    (gain_rd_reg[2*GW-1:GW]),
        .d_gain    (gain_rd_reg[GW-1:0]),
        .ep        (ep_reg),
        .ev        (ev),
        .done      (mac_done),
        .torque    (mac_torque),
        .saturated (mac_sat)
    );

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_MAC) && mac_done && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take_sample)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:  state_next = S_VEL;
            S_VEL:   state_next = S_ERR;
            S_ERR:   state_next = S_MAC;
            S_MAC:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_joint_reg <= joint_reg;
            torque_reg    <= mac_torque;
            stage_out_reg <= stage_used_reg;
            sat_reg       <= mac_sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_joint  = out_joint_reg;
    assign torque_cmd = torque_reg;
    assign stage      = stage_out_reg;
    assign saturated  = sat_reg;

endmodule

`default_nettype wire
